>>> hw/rtl/dte_pkg.sv
package dte_pkg;

   localparam int TABLE_SLOTS   = 64;
   localparam int SLOT_W        = $clog2(TABLE_SLOTS);
   localparam int HINT_W        = $clog2(TABLE_SLOTS + 1);
   localparam int CONSOLE_SLOTS = 3;
   localparam int WRITE_ONLY_BIT = 0;

   localparam logic [HINT_W-1:0] HINT_RESET = HINT_W'(CONSOLE_SLOTS);
   // one bit wider than the slot field so that a 1024-entry table still compares
   localparam logic [10:0] SLOT_LIMIT = 11'(TABLE_SLOTS);

   typedef logic [SLOT_W-1:0] idx_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FILE,
      KIND_CONSOLE,
      KIND_PIPE
   } kind_type;

   typedef enum logic [2:0] {
      ACT_ALLOC,
      ACT_INSTALL,
      ACT_GET,
      ACT_FREE,
      ACT_DUP,
      ACT_DUP2
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_BAD_FD,
      STAT_NO_SLOT
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] flags;
      logic [31:0] handle;
   } entry_type;

   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type entry;
   } wr_type;

   typedef struct packed {
      logic    found;
      logic    first;
      idx_type slot;
   } search_type;

endpackage

>>> hw/rtl/dte_entry_store.sv
module dte_entry_store (
   input  logic               clock,
   input  logic               reset,
   input  dte_pkg::idx_type   rd_addr,
   input  dte_pkg::wr_type    wr,
   output dte_pkg::entry_type rd_entry
);
   import dte_pkg::*;

   entry_type               entry_mem [TABLE_SLOTS];
   entry_type               rd_data_ff;
   idx_type                 rd_addr_ff;
   logic                    rd_valid_ff;
   logic [TABLE_SLOTS-1:0]  valid_ff;
   logic [TABLE_SLOTS-1:0]  valid_in;

   // contents of an entry that has not been written since reset
   function automatic entry_type reset_entry(idx_type a);
      entry_type e;
      e = '0;
      if (int'(a) < CONSOLE_SLOTS) begin
         e.kind   = KIND_CONSOLE;
         e.flags  = {15'd0, a != '0};
         e.handle = 32'(a);
      end
      return e;
   endfunction

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= wr.entry;
      end
      rd_data_ff <= entry_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : reset_entry(rd_addr_ff);

endmodule

>>> hw/rtl/dte_free_search.sv
module dte_free_search (
   input  logic                clock,
   input  logic                reset,
   input  dte_pkg::wr_type     wr,
   input  logic                take_hit,
   output dte_pkg::search_type result
);
   import dte_pkg::*;

   logic [TABLE_SLOTS-1:0] free_ff;
   logic [TABLE_SLOTS-1:0] free_in;
   logic [HINT_W-1:0]      hint_ff;
   logic [HINT_W-1:0]      hint_in;
   search_type             result_ff;
   search_type             result_in;
   logic                   hi_found;
   logic                   lo_found;
   idx_type                hi_idx;
   idx_type                lo_idx;

   always_comb begin
      free_in = free_ff;
      if (wr.en) begin
         free_in[wr.addr] = (wr.entry.kind == KIND_NONE);
      end
   end

   // lowest free slot at or above the hint, else lowest below it
   always_comb begin
      hi_found = 1'b0;
      lo_found = 1'b0;
      hi_idx   = '0;
      lo_idx   = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            if (HINT_W'(i) >= hint_ff) begin
               hi_found = 1'b1;
               hi_idx   = idx_type'(i);
            end else begin
               lo_found = 1'b1;
               lo_idx   = idx_type'(i);
            end
         end
      end
      result_in.found = hi_found | lo_found;
      result_in.first = hi_found;
      result_in.slot  = hi_found ? hi_idx : lo_idx;
   end

   always_comb begin
      hint_in = hint_ff;
      if (take_hit && result_ff.first) begin
         hint_in = HINT_W'(result_ff.slot) + HINT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            free_ff[i] <= (i >= CONSOLE_SLOTS);
         end
         hint_ff   <= HINT_RESET;
         result_ff <= '0;
      end else begin
         free_ff   <= free_in;
         hint_ff   <= hint_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> hw/rtl/descriptor_table_engine.sv
// a transaction is accepted in idle, latches its source entry in ST_SRC and has its result
//   registered when ST_COMMIT commits, which a stalled response holds back; requests
//   stall until idle, as source and target reads share the single read port, then write back
// reset: synchronous; per-entry valid bits make slots 0..2 read as console entries and the
//   rest as empty at once, with no clearing pass; the search hint returns to 3
module descriptor_table_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_slot,
   input  logic [9:0]  req_target_slot,
   input  logic [1:0]  req_entry_kind,
   input  logic [15:0] req_entry_flags,
   input  logic [31:0] req_entry_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_result_slot,
   output logic [1:0]  rsp_kind_out,
   output logic [15:0] rsp_flags_out,
   output logic [31:0] rsp_handle_out,
   output logic [1:0]  rsp_release_kind,
   output logic [31:0] rsp_release_handle,
   output logic        rsp_release_write,
   output logic [1:0]  rsp_retain_kind,
   output logic [31:0] rsp_retain_handle,
   output logic        rsp_retain_write
);
   import dte_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SRC,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] handle;
      logic        write;
   } event_type;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  action_ff;
   logic [9:0]  slot_ff;
   logic [9:0]  target_ff;
   kind_type    ekind_ff;
   logic [15:0] eflags_ff;
   logic [31:0] ehandle_ff;
   entry_type   src_ff;

   status_type  status_ff, status_in;
   logic [9:0]  result_ff, result_in;
   entry_type   get_ff, get_in;
   event_type   rel_ff, rel_in;
   event_type   ret_ff, ret_in;

   logic        req_accept;
   logic        commit;
   logic        s_ok;
   logic        t_ok;
   logic        src_live;
   logic        take_hit;
   idx_type     rd_addr;
   entry_type   rd_entry;
   entry_type   tgt_entry;
   wr_type      wr;
   search_type  search;

   // release or retain event carried by an entry: only files and pipes with a live handle
   function automatic event_type event_of(entry_type e);
      event_type ev;
      ev = '0;
      if ((e.kind == KIND_FILE || e.kind == KIND_PIPE) && e.handle != '0) begin
         ev.kind   = e.kind;
         ev.handle = e.handle;
         ev.write  = (e.kind == KIND_PIPE) && e.flags[WRITE_ONLY_BIT];
      end
      return ev;
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign commit     = (state_ff == ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // source slot in idle, target slot afterwards; the target data holds while committing
   assign rd_addr   = (state_ff == ST_IDLE) ? req_slot[SLOT_W-1:0] : target_ff[SLOT_W-1:0];
   assign tgt_entry = rd_entry;

   assign s_ok     = {1'b0, slot_ff} < SLOT_LIMIT;
   assign t_ok     = {1'b0, target_ff} < SLOT_LIMIT;
   assign src_live = s_ok && (src_ff.kind != KIND_NONE);

   dte_entry_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .wr       (wr),
      .rd_entry (rd_entry)
   );

   dte_free_search u_search (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .take_hit (take_hit),
      .result   (search)
   );

   always_comb begin
      status_in = STAT_OK;
      result_in = '0;
      get_in    = '0;
      rel_in    = '0;
      ret_in    = '0;
      wr        = '0;
      take_hit  = 1'b0;
      case (action_ff)
         ACT_ALLOC: begin
            if (search.found) begin
               result_in = 10'(search.slot);
               take_hit  = 1'b1;
            end else begin
               status_in = STAT_NO_SLOT;
            end
         end
         ACT_INSTALL: begin
            if (!s_ok) begin
               status_in = STAT_BAD_FD;
            end else begin
               wr.en           = 1'b1;
               wr.addr         = slot_ff[SLOT_W-1:0];
               wr.entry.kind   = ekind_ff;
               wr.entry.flags  = eflags_ff;
               wr.entry.handle = ehandle_ff;
            end
         end
         ACT_GET: begin
            if (!src_live) begin
               status_in = STAT_BAD_FD;
            end else begin
               get_in = src_ff;
            end
         end
         ACT_FREE: begin
            if (!s_ok) begin
               status_in = STAT_BAD_FD;
            end else begin
               rel_in   = event_of(src_ff);
               wr.en    = 1'b1;
               wr.addr  = slot_ff[SLOT_W-1:0];
               wr.entry = '0;
            end
         end
         ACT_DUP: begin
            if (!src_live) begin
               status_in = STAT_BAD_FD;
            end else if (!search.found) begin
               status_in = STAT_NO_SLOT;
            end else begin
               take_hit  = 1'b1;
               wr.en     = 1'b1;
               wr.addr   = search.slot;
               wr.entry  = src_ff;
               ret_in    = event_of(src_ff);
               result_in = 10'(search.slot);
            end
         end
         ACT_DUP2: begin
            if (!src_live) begin
               status_in = STAT_BAD_FD;
            end else if (slot_ff == target_ff) begin
               result_in = target_ff;
            end else if (!t_ok) begin
               status_in = STAT_BAD_FD;
            end else begin
               rel_in   = event_of(tgt_entry);
               ret_in   = event_of(src_ff);
               wr.en    = 1'b1;
               wr.addr  = target_ff[SLOT_W-1:0];
               wr.entry = src_ff;
               // a live file gets the handle of the cloned file object
               if (ret_in.kind == KIND_FILE) begin
                  wr.entry.handle = ehandle_ff;
                  ret_in.handle   = ehandle_ff;
               end
               result_in = target_ff;
            end
         end
         default: begin
         end
      endcase
      if (!commit) begin
         wr.en    = 1'b0;
         take_hit = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SRC;
            end
         end
         ST_SRC: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         action_ff  <= req_action;
         slot_ff    <= req_slot;
         target_ff  <= req_target_slot;
         ekind_ff   <= kind_type'(req_entry_kind);
         eflags_ff  <= req_entry_flags;
         ehandle_ff <= req_entry_handle;
      end
      if (state_ff == ST_SRC) begin
         src_ff <= rd_entry;
      end
      if (commit) begin
         status_ff <= status_in;
         result_ff <= result_in;
         get_ff    <= get_in;
         rel_ff    <= rel_in;
         ret_ff    <= ret_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_slot    = result_ff;
   assign rsp_kind_out       = get_ff.kind;
   assign rsp_flags_out      = get_ff.flags;
   assign rsp_handle_out     = get_ff.handle;
   assign rsp_release_kind   = rel_ff.kind;
   assign rsp_release_handle = rel_ff.handle;
   assign rsp_release_write  = rel_ff.write;
   assign rsp_retain_kind    = ret_ff.kind;
   assign rsp_retain_handle  = ret_ff.handle;
   assign rsp_retain_write   = ret_ff.write;

endmodule

>>> hw/rtl/dte_checker.sv
module dte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [9:0]  rsp_result_slot,
   input logic [1:0]  rsp_kind_out,
   input logic [31:0] rsp_handle_out,
   input logic [1:0]  rsp_release_kind,
   input logic        rsp_release_write,
   input logic [1:0]  rsp_retain_kind,
   input logic        rsp_retain_write
);
   import dte_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_slot) && $stable(rsp_handle_out))
      else $error("response changed while stalled");

   // one transaction in flight: the request side is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a transaction was in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a failed transaction reports no slot, no entry and no resource event
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_result_slot == '0
         && rsp_release_kind == KIND_NONE && rsp_retain_kind == KIND_NONE
         && rsp_kind_out == KIND_NONE)
      else $error("failed transaction carries results");

   a_write_side_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_release_write || rsp_retain_write) |->
         (!rsp_release_write || rsp_release_kind == KIND_PIPE)
         && (!rsp_retain_write || rsp_retain_kind == KIND_PIPE))
      else $error("write side marked on a non-pipe event");

endmodule

bind descriptor_table_engine dte_checker u_checker (.*);
